// File: hw/rtl/isso_pkg.sv
package isso_pkg;

   // Field widths
   localparam int FUNC_W     = 2;
   localparam int SAMPLE_W   = 12;
   localparam int SEL_W      = 3;
   localparam int CHAN_W     = 5;
   localparam int AVG_W      = 14;
   localparam int ACT_W      = 3;
   localparam int CSR_ADDR_W = 3;

   // Channel registers, one per front sensor
   localparam int CHAN_REGS  = 5;
   localparam int SAMPLE_MAX = 4095;

   // Parameter defaults
   localparam int OVERSAMPLE_DEF   = 32;
   localparam int SENSOR_COUNT_DEF = 5;

   localparam logic [CHAN_W-1:0] CHAN_RESET [CHAN_REGS] =
      '{5'd10, 5'd12, 5'd11, 5'd13, 5'd2};

   // Request kind on the input stream
   typedef enum logic [FUNC_W-1:0] {
      FUNC_EMIT   = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_DONE   = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   // Operation handed from the front to the back
   typedef enum logic [1:0] {
      OP_EMIT,
      OP_CONVERT,
      OP_ACCUM,
      OP_READ
   } op_type;

   // Result kind on the output stream
   typedef enum logic [ACT_W-1:0] {
      ACT_EMIT_ON  = 3'd1,
      ACT_CONVERT  = 3'd2,
      ACT_EMIT_OFF = 3'd3,
      ACT_READ     = 3'd4
   } action_type;

   // Classified request as queued between front and back
   typedef struct packed {
      op_type              op;
      logic [SAMPLE_W-1:0] sample;
      logic [SEL_W-1:0]    idx;
   } item_type;

endpackage

// File: hw/rtl/isso_front.sv
module isso_front
   import isso_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [FUNC_W-1:0]   in_func,
   input  logic [SAMPLE_W-1:0] in_sample,
   input  logic [SEL_W-1:0]    in_idx,
   output logic                out_valid,
   input  logic                out_ready,
   output item_type            out_item
);

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   // Classify the request kind
   always_comb begin
      item_in.sample = in_sample;
      item_in.idx    = in_idx;
      unique case (func_type'(in_func))
         FUNC_EMIT:   item_in.op = OP_EMIT;
         FUNC_SAMPLE: item_in.op = OP_CONVERT;
         FUNC_DONE:   item_in.op = OP_ACCUM;
         FUNC_READ:   item_in.op = OP_READ;
         default:     item_in.op = OP_EMIT;
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Hold the classified request until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: hw/rtl/isso_queue.sv
module isso_queue
   import isso_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/isso_back.sv
module isso_back
   import isso_pkg::*;
#(
   parameter int OVERSAMPLE   = OVERSAMPLE_DEF,
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CHAN_W-1:0]     csr_wdata,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  item_type              in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [ACT_W-1:0]      out_action,
   output logic [SEL_W-1:0]      out_sel,
   output logic [CHAN_W-1:0]     out_chan,
   output logic [AVG_W-1:0]      out_avg,
   output logic [AVG_W-1:0]      out_read
);

   // Divide by OVERSAMPLE+1 as multiply by a rounded-up reciprocal; exact for
   // every dividend below 2**DIV_W.
   localparam int DIVISOR = OVERSAMPLE + 1;
   localparam int CNT_W   = $clog2(OVERSAMPLE + 1);
   localparam int SUM_W   = $clog2((OVERSAMPLE + 1) * SAMPLE_MAX + 1);
   localparam int DIV_W   = SUM_W + 2;
   localparam int SHIFT   = DIV_W + $clog2(DIVISOR);
   localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam int MUL_W   = DIV_W + 1;
   localparam int PROD_W  = (DIV_W + MUL_W > SHIFT + AVG_W) ? DIV_W + MUL_W
                                                            : SHIFT + AVG_W;

   // Channel registers
   logic [CHAN_W-1:0] chan_ff [CHAN_REGS];

   // Scan state
   logic [SEL_W-1:0] cur_ff,   cur_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff,   sum_in;

   // Execute stage
   logic              a_valid_ff;
   action_type        a_action_ff, a_action_in;
   logic [SEL_W-1:0]  a_sel_ff,    a_sel_in;
   logic [CHAN_W-1:0] a_chan_ff,   a_chan_in;
   logic [SUM_W-1:0]  a_sum_ff,    a_sum_in;

   // Output stage
   logic              o_valid_ff;
   logic [ACT_W-1:0]  o_action_ff;
   logic [SEL_W-1:0]  o_sel_ff;
   logic [CHAN_W-1:0] o_chan_ff;
   logic [AVG_W-1:0]  o_avg_ff,  o_avg_in;
   logic [AVG_W-1:0]  o_read_ff, o_read_in;

   // Stored averages
   logic [AVG_W-1:0] avg_ff [SENSOR_COUNT];

   logic              out_free;
   logic              a_move;
   logic              pop;
   logic [SUM_W-1:0]  sum_add;
   logic [CHAN_W-1:0] cur_chan;
   logic [SEL_W:0]    cur_next;
   logic [PROD_W-1:0] product;

   assign out_free = !o_valid_ff || out_ready;
   assign a_move   = a_valid_ff && out_free;
   assign in_ready = !a_valid_ff || out_free;
   assign pop      = in_valid && in_ready;

   // Write channel registers; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAN_REGS; i++) begin
            chan_ff[i] <= CHAN_RESET[i];
         end
      end else if (csr_we && (csr_addr < CSR_ADDR_W'(CHAN_REGS))) begin
         chan_ff[csr_addr] <= csr_wdata;
      end
   end

   // Look up the current sensor's channel
   assign cur_chan = (cur_ff < SEL_W'(CHAN_REGS)) ? chan_ff[cur_ff] : '0;
   assign sum_add  = sum_ff + SUM_W'(in_item.sample);
   assign cur_next = {1'b0, cur_ff} + (SEL_W + 1)'(1);

   // Execute one request against the scan state
   always_comb begin
      cur_in      = cur_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      a_action_in = ACT_EMIT_ON;
      a_sel_in    = cur_ff;
      a_chan_in   = '0;
      a_sum_in    = sum_add;
      case (in_item.op)
         OP_EMIT: begin
            a_action_in = ACT_EMIT_ON;
         end
         OP_CONVERT: begin
            a_action_in = ACT_CONVERT;
            a_chan_in   = cur_chan;
         end
         OP_ACCUM: begin
            if (count_ff < CNT_W'(OVERSAMPLE)) begin
               count_in    = count_ff + CNT_W'(1);
               sum_in      = sum_add;
               a_action_in = ACT_CONVERT;
               a_chan_in   = cur_chan;
            end else begin
               count_in    = '0;
               sum_in      = '0;
               a_action_in = ACT_EMIT_OFF;
               if (cur_next >= (SEL_W + 1)'(SENSOR_COUNT)) begin
                  cur_in = '0;
               end else begin
                  cur_in = cur_next[SEL_W-1:0];
               end
            end
         end
         default: begin
            a_action_in = ACT_READ;
            a_sel_in    = in_item.idx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         count_ff   <= '0;
         sum_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_ff   <= cur_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
         end
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
      end
      if (pop) begin
         a_action_ff <= a_action_in;
         a_sel_ff    <= a_sel_in;
         a_chan_ff   <= a_chan_in;
         a_sum_ff    <= a_sum_in;
      end
   end

   // Scale the finished sum by four and divide
   assign product = PROD_W'({a_sum_ff, 2'b00}) * PROD_W'(RECIP[MUL_W-1:0]);

   // Form the average and the read reply
   always_comb begin
      o_avg_in  = '0;
      o_read_in = '0;
      if (a_action_ff == ACT_EMIT_OFF) begin
         o_avg_in = product[SHIFT +: AVG_W];
      end
      if (a_action_ff == ACT_READ) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (a_sel_ff == SEL_W'(i)) begin
               o_read_in = avg_ff[i];
            end
         end
      end
   end

   // Store averages and register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            avg_ff[i] <= '0;
         end
      end else begin
         if (out_free) begin
            o_valid_ff <= a_valid_ff;
         end
         if (a_move && (a_action_ff == ACT_EMIT_OFF)) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               if (a_sel_ff == SEL_W'(i)) begin
                  avg_ff[i] <= o_avg_in;
               end
            end
         end
      end
      if (a_move) begin
         o_action_ff <= a_action_ff;
         o_sel_ff    <= a_sel_ff;
         o_chan_ff   <= a_chan_ff;
         o_avg_ff    <= o_avg_in;
         o_read_ff   <= o_read_in;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_action = o_action_ff;
   assign out_sel    = o_sel_ff;
   assign out_chan   = o_chan_ff;
   assign out_avg    = o_avg_ff;
   assign out_read   = o_read_ff;

endmodule

// File: hw/rtl/ir_sensor_scan_oversample_avg_core.sv
// Path: a request passes through the front register, the two-entry queue, the
// execute stage and the output register before its response shows on the port.
// Throughput: one request per cycle while responses are taken without stall.
// Reset (synchronous, active high) empties all stages, restores the channel
// registers, and clears scan position, sample count, sum and stored averages.
module ir_sensor_scan_oversample_avg_core
   import isso_pkg::*;
#(
   parameter int OVERSAMPLE   = OVERSAMPLE_DEF,
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CHAN_W-1:0]     csr_wdata,
   // Requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // sample, sensor_index, zero fill
   input  logic [FUNC_W-1:0]     req_tuser,   // func
   // Responses
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // sensor_sel, adc_channel,
                                              // average_value, read_value, zero fill
   output logic [ACT_W-1:0]      rsp_tuser    // action
);

   logic              f_valid;
   logic              f_ready;
   item_type          f_item;
   logic              q_valid;
   logic              q_ready;
   item_type          q_item;
   logic [SEL_W-1:0]  rsp_sel;
   logic [CHAN_W-1:0] rsp_chan;
   logic [AVG_W-1:0]  rsp_avg;
   logic [AVG_W-1:0]  rsp_read;

   // Accept and classify requests
   isso_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tuser),
      .in_sample (req_tdata[SAMPLE_W-1:0]),
      .in_idx    (req_tdata[SAMPLE_W +: SEL_W]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   // Decouple front and back
   isso_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   // Scan, accumulate, average and answer reads
   isso_back #(
      .OVERSAMPLE   (OVERSAMPLE),
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .in_valid   (q_valid),
      .in_ready   (q_ready),
      .in_item    (q_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_action (rsp_tuser),
      .out_sel    (rsp_sel),
      .out_chan   (rsp_chan),
      .out_avg    (rsp_avg),
      .out_read   (rsp_read)
   );

   assign rsp_tdata = {4'b0000, rsp_read, rsp_avg, rsp_chan, rsp_sel};

endmodule

// File: sim/tb.sv
module tb
   import isso_pkg::*;
();

   // One expected response, split into its fields
   typedef struct {
      logic [ACT_W-1:0]  act;
      logic [SEL_W-1:0]  sel;
      logic [CHAN_W-1:0] chan;
      logic [AVG_W-1:0]  avg;
      logic [AVG_W-1:0]  rd;
   } scan_result_type;

   // Directed request with an optional hand-written response
   typedef struct {
      func_type            f;
      logic [SAMPLE_W-1:0] smp;
      logic [SEL_W-1:0]    ix;
      bit                  typed;
      logic [ACT_W-1:0]    act;
      logic [SEL_W-1:0]    sel;
      logic [CHAN_W-1:0]   chan;
      logic [AVG_W-1:0]    avg;
      logic [AVG_W-1:0]    rd;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 18;
   localparam int PHASE_ITEMS   = 225;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CHAN_W-1:0]     csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // sample, sensor_index, zero fill
   logic [FUNC_W-1:0]     req_tuser;   // func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [39:0]           rsp_tdata;   // sensor_sel, adc_channel, average_value,
                                       // read_value, zero fill
   logic [ACT_W-1:0]      rsp_tuser;   // action

   // Scanner state as the block should hold it
   logic [CHAN_W-1:0] chan_cfg [CHAN_REGS];
   int unsigned       scan_pos;
   int unsigned       shot_count;
   int unsigned       shot_sum;
   logic [AVG_W-1:0]  avg_store [8];

   scan_result_type pending_results [$];
   int              fail_count = 0;
   int              items_sent = 0;
   bit              sender_steady = 1'b0;
   bit              receiver_steady = 1'b0;

   // Directed requests starting from the reset state
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{FUNC_READ,   12'd0,    3'd0, 1'b1, ACT_READ,     3'd0, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'd0,    3'd1, 1'b1, ACT_READ,     3'd1, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'd0,    3'd2, 1'b1, ACT_READ,     3'd2, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'd0,    3'd3, 1'b1, ACT_READ,     3'd3, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'hFFF,  3'd4, 1'b1, ACT_READ,     3'd4, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'd0,    3'd5, 1'b1, ACT_READ,     3'd5, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'd0,    3'd6, 1'b1, ACT_READ,     3'd6, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'd0,    3'd7, 1'b1, ACT_READ,     3'd7, 5'd0,  14'd0, 14'd0},
      '{FUNC_EMIT,   12'd0,    3'd0, 1'b1, ACT_EMIT_ON,  3'd0, 5'd0,  14'd0, 14'd0},
      '{FUNC_SAMPLE, 12'd0,    3'd0, 1'b1, ACT_CONVERT,  3'd0, 5'd10, 14'd0, 14'd0},
      '{FUNC_DONE,   12'hFFF,  3'd7, 1'b1, ACT_CONVERT,  3'd0, 5'd10, 14'd0, 14'd0},
      '{FUNC_DONE,   12'd0,    3'd0, 1'b1, ACT_CONVERT,  3'd0, 5'd10, 14'd0, 14'd0},
      '{FUNC_SAMPLE, 12'hFFF,  3'd7, 1'b1, ACT_CONVERT,  3'd0, 5'd10, 14'd0, 14'd0},
      '{FUNC_EMIT,   12'hFFF,  3'd7, 1'b1, ACT_EMIT_ON,  3'd0, 5'd0,  14'd0, 14'd0},
      '{FUNC_DONE,   12'hAAA,  3'd2, 1'b0, ACT_CONVERT,  3'd0, 5'd0,  14'd0, 14'd0},
      '{FUNC_DONE,   12'h555,  3'd5, 1'b0, ACT_CONVERT,  3'd0, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'hFFF,  3'd0, 1'b1, ACT_READ,     3'd0, 5'd0,  14'd0, 14'd0},
      '{FUNC_READ,   12'd0,    3'd7, 1'b1, ACT_READ,     3'd7, 5'd0,  14'd0, 14'd0}
   };

   ir_sensor_scan_oversample_avg_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   function automatic void clear_scan_state();
      for (int i = 0; i < CHAN_REGS; i++) chan_cfg[i] = CHAN_RESET[i];
      for (int i = 0; i < 8; i++) avg_store[i] = '0;
      scan_pos   = 0;
      shot_count = 0;
      shot_sum   = 0;
   endfunction

   function automatic logic [CHAN_W-1:0] channel_for(int unsigned s);
      return (s < CHAN_REGS) ? chan_cfg[s] : '0;
   endfunction

   // Compute the response to one request and advance the scan state
   function automatic scan_result_type scan_predict(func_type f, logic [SAMPLE_W-1:0] smp,
                                                    logic [SEL_W-1:0] ix);
      scan_result_type r;
      int unsigned     quotient;
      r = '{act: '0, sel: '0, chan: '0, avg: '0, rd: '0};
      case (f)
         FUNC_EMIT: begin
            r.act = ACT_EMIT_ON;
            r.sel = SEL_W'(scan_pos);
         end
         FUNC_SAMPLE: begin
            r.act  = ACT_CONVERT;
            r.sel  = SEL_W'(scan_pos);
            r.chan = channel_for(scan_pos);
         end
         FUNC_DONE: begin
            shot_sum += smp;
            r.sel = SEL_W'(scan_pos);
            if (shot_count < OVERSAMPLE_DEF) begin
               shot_count++;
               r.act  = ACT_CONVERT;
               r.chan = channel_for(scan_pos);
            end else begin
               // Last sample of the burst: store the average, move to the next sensor
               quotient = (shot_sum * 4) / (OVERSAMPLE_DEF + 1);
               r.act = ACT_EMIT_OFF;
               r.avg = AVG_W'(quotient);
               avg_store[scan_pos] = r.avg;
               shot_count = 0;
               shot_sum   = 0;
               scan_pos   = (scan_pos + 1 >= SENSOR_COUNT_DEF) ? 0 : scan_pos + 1;
            end
         end
         default: begin
            r.act = ACT_READ;
            r.sel = ix;
            if (ix < SENSOR_COUNT_DEF) r.rd = avg_store[ix];
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Present one request after a random gap and record its response at acceptance
   task automatic send_request(func_type f, logic [SAMPLE_W-1:0] smp, logic [SEL_W-1:0] ix);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {1'b0, ix, smp};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(scan_predict(f, smp, ix));
      items_sent++;
      if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
   endtask

   // Hold off requests until every response is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Write all channel registers plus the unused indexes above them
   task automatic load_channels(int setting);
      logic [CHAN_W-1:0] v;
      for (int a = 0; a < 8; a++) begin
         case (setting)
            0:       v = '1;
            1:       v = '0;
            2:       v = 5'd18;
            default: v = CHAN_W'($urandom_range(0, 18));
         endcase
         if (a >= CHAN_REGS) v = CHAN_W'($urandom);
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(a);
         csr_wdata <= v;
         @(posedge clock);
         if (a < CHAN_REGS) chan_cfg[a] = v;
      end
      csr_we <= 1'b0;
   endtask

   // Emitter on, first conversion, then a burst of conversion-done requests
   // with an occasional unrelated request mixed in
   task automatic run_scan_pass(int done_items, int pattern);
      logic [SAMPLE_W-1:0] smp;
      func_type            side_f;
      send_request(FUNC_EMIT, SAMPLE_W'($urandom), SEL_W'($urandom));
      send_request(FUNC_SAMPLE, SAMPLE_W'($urandom), SEL_W'($urandom));
      for (int i = 0; i < done_items; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            side_f = func_type'($urandom_range(0, 2));
            if (side_f == FUNC_DONE) side_f = FUNC_READ;
            send_request(side_f, SAMPLE_W'($urandom), SEL_W'($urandom));
         end
         case (pattern)
            0:       smp = '0;
            1:       smp = SAMPLE_W'(SAMPLE_MAX);
            2:       smp = i[0] ? 12'hAAA : 12'h555;
            default: smp = SAMPLE_W'($urandom);
         endcase
         send_request(FUNC_DONE, smp, SEL_W'($urandom));
      end
   endtask

   // Response side: random stall before each response
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_steady ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if ($urandom_range(0, 39) == 0) receiver_steady = !receiver_steady;
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin : check_responses
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("action", want.act, rsp_tuser);
            check_field("sensor_sel", want.sel, rsp_tdata[2:0]);
            check_field("adc_channel", want.chan, rsp_tdata[7:3]);
            check_field("average_value", want.avg, rsp_tdata[21:8]);
            check_field("read_value", want.rd, rsp_tdata[35:22]);
         end
      end
   end

   initial begin
      int phase_end;
      int pick;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_EMIT;
      clear_scan_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table on reset configuration
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].f, directed_rows[i].smp, directed_rows[i].ix);
         if (directed_rows[i].typed)
            pending_results[pending_results.size() - 1] = '{
               act: directed_rows[i].act, sel: directed_rows[i].sel,
               chan: directed_rows[i].chan, avg: directed_rows[i].avg,
               rd: directed_rows[i].rd};
      end
      drain_results();

      // Random phases, one channel setting each
      for (int phase = 0; phase < 4; phase++) begin
         load_channels(phase);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
               run_scan_pass((pick == 0) ? $urandom_range(1, OVERSAMPLE_DEF) :
                             OVERSAMPLE_DEF + 1, $urandom_range(0, 4));
            else
               repeat ($urandom_range(5, 15))
                  send_request(func_type'($urandom_range(0, 3)), SAMPLE_W'($urandom),
                               SEL_W'($urandom));
            if ($urandom_range(0, 3) == 0) drain_results();
         end
         drain_results();
      end

      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
